// ----- rtl/core/compacting_quantile_tracker_macros.svh -----
// assertion macros for the quantile tracker checker
`ifndef COMPACTING_QUANTILE_TRACKER_MACROS_SVH
`define COMPACTING_QUANTILE_TRACKER_MACROS_SVH
// property a implies b on the next cycle
`define CQT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("violation");
// property a implies b in the same cycle
`define CQT_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("violation");
`endif

// ----- rtl/core/cqt_pkg.sv -----
// ----------------------------------------------------------------------------
// cqt_pkg
// shared types and constants of the compacting quantile tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cqt_pkg;
  localparam int MaxValues = 1024;
  localparam int StoreCap = MaxValues + (MaxValues % 2);
  localparam int AddrW = $clog2(StoreCap);
  localparam int CountW = $clog2(StoreCap + 1);
  localparam int HalfCap = StoreCap / 2;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic signed [31:0] sample_value;
    logic [16:0] quantile_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] quantile_value;
    logic [10:0] stored_count;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCAN_RD, OP_SCAN_CMP, OP_SHIFT_RD, OP_SHIFT_WR, OP_PUT,
    OP_CMP_RD, OP_CMP_A, OP_CMP_WR, OP_Q_SETUP, OP_Q_RD0, OP_Q_RD1, OP_Q_MUL,
    OP_Q_SUM
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;  // insert position found
    logic shift_done; // all entries above position moved
    logic full;       // count reached capacity
    logic cmp_done;   // compaction finished
    logic q_direct;   // query result ready in qval
  } dp_status_t;
endpackage
`default_nettype wire

// ----- rtl/core/cqt_datapath.sv -----
// ----------------------------------------------------------------------------
// cqt_datapath
// sorted store memory, count, insertion, compaction and interpolation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cqt_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cqt_pkg::in_item_t   item,
  input  wire cqt_pkg::dp_cmd_t    ctl,
  output cqt_pkg::dp_status_t      status,
  output cqt_pkg::out_item_t       result
);
  import cqt_pkg::*;

  logic signed [31:0] mem [StoreCap];
  logic signed [31:0] rdata;
  logic [AddrW-1:0]   raddr;
  logic               wen;
  logic [AddrW-1:0]   waddr;
  logic signed [31:0] wdata;

  logic [CountW-1:0]  count;
  logic [CountW-1:0]  ptr;
  logic [CountW-1:0]  pos;
  logic signed [31:0] sample;
  logic [16:0]        frac;
  logic signed [31:0] hold;
  logic               direct;
  logic [15:0]        fpart;
  logic signed [31:0] s0;
  logic signed [48:0] p0;
  logic signed [48:0] p1;
  logic signed [31:0] qval;
  logic [CountW+16:0] qpos;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign qpos = CountW'(count - 1'b1) * frac;

  always_comb begin
    raddr = '0;
    wen = 1'b0;
    waddr = '0;
    wdata = '0;
    case (ctl.op)
      OP_SCAN_RD: raddr = ptr[AddrW-1:0];
      OP_SHIFT_RD: raddr = AddrW'(ptr - 1'b1);
      OP_SHIFT_WR: begin
        wen = 1'b1;
        waddr = ptr[AddrW-1:0];
        wdata = rdata;
      end
      OP_PUT: begin
        wen = 1'b1;
        waddr = pos[AddrW-1:0];
        wdata = sample;
      end
      OP_CMP_RD: raddr = AddrW'({ptr, 1'b0});
      OP_CMP_A: raddr = AddrW'({ptr, 1'b1});
      OP_CMP_WR: begin
        wen = 1'b1;
        waddr = ptr[AddrW-1:0];
        wdata = 32'(($signed({hold[31], hold}) + $signed({rdata[31], rdata})) >>> 1);
      end
      OP_Q_RD0: raddr = ptr[AddrW-1:0];
      OP_Q_RD1: raddr = AddrW'(ptr + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          sample <= item.sample_value;
          frac <= item.quantile_fraction;
          ptr <= '0;
        end
        OP_SCAN_RD: ;
        OP_SCAN_CMP: begin
          if (ptr < count && rdata <= sample) begin
            ptr <= ptr + 1'b1;
          end else begin
            pos <= ptr;
            ptr <= count;
          end
        end
        OP_SHIFT_RD: ;
        OP_SHIFT_WR: ptr <= ptr - 1'b1;
        OP_PUT: begin
          count <= count + 1'b1;
          ptr <= '0;
        end
        OP_CMP_RD: ;
        OP_CMP_A: hold <= rdata;
        OP_CMP_WR: begin
          if (ptr == CountW'(HalfCap - 1)) begin
            count <= CountW'(HalfCap);
          end
          ptr <= ptr + 1'b1;
        end
        OP_Q_SETUP: begin
          direct <= 1'b1;
          if (count == '0) begin
            qval <= '0;
          end else if (count == CountW'(1) || frac == '0) begin
            ptr <= '0;
            direct <= 1'b0;
            fpart <= '0;
          end else if (frac[16]) begin
            ptr <= count - 1'b1;
            fpart <= '0;
            direct <= 1'b0;
          end else begin
            ptr <= qpos[CountW+15:16];
            fpart <= qpos[15:0];
            direct <= 1'b0;
            if (qpos[CountW+15:16] + 1'b1 >= count) begin
              ptr <= count - 1'b1;
              fpart <= '0;
            end
          end
        end
        OP_Q_RD0: ;
        OP_Q_RD1: s0 <= rdata;
        OP_Q_MUL: begin
          p0 <= s0 * $signed({1'b0, 17'(17'h10000 - fpart)});
          p1 <= (fpart == '0) ? 49'sd0 : rdata * $signed({1'b0, fpart});
        end
        OP_Q_SUM: begin
          qval <= 32'((p0 + p1) >>> 16);
          direct <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status.scan_done = !(ptr < count && rdata <= sample);
  assign status.shift_done = (ptr == pos);
  assign status.full = (count == CountW'(StoreCap));
  assign status.cmp_done = (ptr == CountW'(HalfCap - 1));
  assign status.q_direct = direct;
  assign result.quantile_value = qval;
  assign result.stored_count = 11'(count);
endmodule
`default_nettype wire

// ----- rtl/core/cqt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cqt_ctrl
// sequencer for insertion, compaction and query, with output valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cqt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire cqt_pkg::dp_status_t status,
  output cqt_pkg::dp_cmd_t        ctl,
  output logic                    out_load
);
  import cqt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001, S_SCANR = 15'h0002, S_SCANC = 15'h0004,
    S_SHR    = 15'h0008, S_SHW   = 15'h0010, S_PUT   = 15'h0020,
    S_CHK    = 15'h0040, S_CRD   = 15'h0080, S_CA    = 15'h0100,
    S_CWR    = 15'h0200, S_QSET  = 15'h0400, S_QRD0  = 15'h0800,
    S_QRD1   = 15'h1000, S_QMUL  = 15'h2000, S_QSUM  = 15'h4000
  } state_t;

  state_t state, state_next;
  logic   hold_cmd;
  logic   q_fin;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    ctl.op = OP_NONE;
    q_fin = 1'b0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        ctl.op = OP_LOAD;
        state_next = (in_cmd == CMD_QUERY) ? S_QSET : S_SCANR;
      end
      S_SCANR: begin
        ctl.op = OP_SCAN_RD;
        state_next = S_SCANC;
      end
      S_SCANC: begin
        ctl.op = OP_SCAN_CMP;
        state_next = status.scan_done ? S_SHR : S_SCANR;
      end
      S_SHR: begin
        if (status.shift_done) begin
          state_next = S_PUT;
        end else begin
          ctl.op = OP_SHIFT_RD;
          state_next = S_SHW;
        end
      end
      S_SHW: begin
        ctl.op = OP_SHIFT_WR;
        state_next = S_SHR;
      end
      S_PUT: begin
        ctl.op = OP_PUT;
        state_next = S_CHK;
      end
      S_CHK: state_next = status.full ? S_CRD : S_IDLE;
      S_CRD: begin
        ctl.op = OP_CMP_RD;
        state_next = S_CA;
      end
      S_CA: begin
        ctl.op = OP_CMP_A;
        state_next = S_CWR;
      end
      S_CWR: begin
        ctl.op = OP_CMP_WR;
        state_next = status.cmp_done ? S_IDLE : S_CRD;
      end
      S_QSET: begin
        ctl.op = OP_Q_SETUP;
        state_next = S_QRD0;
      end
      S_QRD0: begin
        if (status.q_direct) begin
          q_fin = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.op = OP_Q_RD0;
          state_next = S_QRD1;
        end
      end
      S_QRD1: begin
        ctl.op = OP_Q_RD1;
        state_next = S_QMUL;
      end
      S_QMUL: begin
        ctl.op = OP_Q_MUL;
        state_next = S_QSUM;
      end
      // result register settles, then handed out from the read state
      S_QSUM: begin
        ctl.op = OP_Q_SUM;
        state_next = S_QRD0;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_load = q_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      hold_cmd <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        hold_cmd <= in_cmd;
      end
      if (q_fin && hold_cmd == CMD_QUERY) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/compacting_quantile_tracker.sv -----
// Approximate quantile tracker. An add scans the n stored entries up to insert position p
// and then shifts the n-p entries above it, one at a time through the single memory port;
// the add that fills the store also runs a compaction that averages adjacent pairs.
// A query returns one transaction; an add returns none.
// ----------------------------------------------------------------------------
// compacting_quantile_tracker
// top level: controller, datapath and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module compacting_quantile_tracker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cqt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cqt_pkg::out_item_t      out_data
);
  import cqt_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t status;
  out_item_t  result;
  logic       out_load;

  cqt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_cmd(in_data.cmd),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .ctl(ctl), .out_load(out_load)
  );

  cqt_datapath u_dp (
    .clk(clk), .rst(rst), .item(in_data), .ctl(ctl), .status(status),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/cqt_checker.sv -----
// ----------------------------------------------------------------------------
// cqt_checker
// port-level checks of the quantile tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "compacting_quantile_tracker_macros.svh"
module cqt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire cqt_pkg::out_item_t out_data
);
  `CQT_ASSERT_NOW(a_no_take_while_out, clk, rst, out_valid, !in_ready)
  `CQT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `CQT_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `CQT_ASSERT_NOW(a_count_range, clk, rst, out_valid, out_data.stored_count < 11'd1024)
endmodule
bind compacting_quantile_tracker cqt_checker u_cqt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the quantile tracker: adds and queries go through a sorted-store
// predictor, and every query transaction is compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import cqt_pkg::*;

  class quantile_scoreboard;
    logic signed [31:0] store [StoreCap];
    int count;
    out_item_t pending[$];
    int errors;
    int queries;

    function void add_sample(logic signed [31:0] v);
      int p;
      longint s;
      p = 0;
      while (p < count && store[p] <= v) p++;
      for (int k = count; k > p; k--) store[k] = store[k - 1];
      store[p] = v;
      count++;
      if (count == StoreCap) begin
        for (int k = 0; k < HalfCap; k++) begin
          s = longint'(store[2 * k]) + longint'(store[2 * k + 1]);
          store[k] = 32'(s >>> 1);
        end
        count = HalfCap;
      end
    endfunction

    function logic signed [31:0] interpolate(logic [16:0] t);
      longint pos, f, acc;
      int i;
      if (count == 0) return 0;
      if (count == 1 || t == 0) return store[0];
      if (t >= 17'd65536) return store[count - 1];
      pos = longint'(t) * longint'(count - 1);
      i = int'(pos >> 16);
      f = pos & 64'hffff;
      if (i + 1 >= count) return store[count - 1];
      acc = longint'(store[i]) * (65536 - f) + longint'(store[i + 1]) * f;
      return 32'(acc >>> 16);
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      if (it.cmd == CMD_ADD) begin
        add_sample(it.sample_value);
      end else begin
        r.quantile_value = interpolate(it.quantile_fraction);
        r.stored_count = 11'(count);
        pending.push_back(r);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      queries++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction value %0d count %0d", $time,
                 got.quantile_value, got.stored_count);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.quantile_value !== exp_r.quantile_value) begin
        $display("%0t: quantile_value expected %0d actual %0d", $time,
                 exp_r.quantile_value, got.quantile_value);
        errors++;
      end
      if (got.stored_count !== exp_r.stored_count) begin
        $display("%0t: stored_count expected %0d actual %0d", $time,
                 exp_r.stored_count, got.stored_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  quantile_scoreboard sb;
  int cycles;
  bit no_idle;

  compacting_quantile_tracker dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 35);
  end

  task automatic send(in_item_t it);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add(logic signed [31:0] v);
    in_item_t it;
    it.cmd = CMD_ADD;
    it.sample_value = v;
    it.quantile_fraction = 17'($urandom);
    send(it);
  endtask

  task automatic query(logic [16:0] t);
    in_item_t it;
    it.cmd = CMD_QUERY;
    it.sample_value = $urandom;
    it.quantile_fraction = t;
    send(it);
  endtask

  function automatic logic [16:0] rand_fraction();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65536, 131071));
      default: return 17'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(4))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'($urandom_range(0, 20)) - 32'sd10;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cycles = 0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store, single entry, extremes, duplicates
    query(17'd0);
    query(17'd32768);
    add(32'sh7fffffff);
    query(17'd32768);
    add(32'sh80000000);
    query(17'd0);
    query(17'd65536);
    query(17'h1ffff);
    query(17'd32768);
    query(17'd1);
    query(17'd65535);
    add(32'sd5);
    add(32'sd5);
    add(-32'sd3);
    query(17'd21845);
    query(17'd43690);
    add(32'h55555555);
    add(32'haaaaaaaa);
    query(17'h0aaaa);
    query(17'h15555);

    // random mix of adds and queries
    for (int n = 0; n < 550; n++) begin
      no_idle = (n >= 200 && n < 280);
      if ($urandom_range(99) < 30) query(rand_fraction());
      else add(rand_sample());
    end
    no_idle = 1'b0;
    for (int n = 0; n < 10; n++) query(rand_fraction());
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d query transactions checked; store ended with %0d entries",
             sb.queries, sb.count);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- compacting_quantile_tracker.f -----
+incdir+rtl/core
rtl/core/cqt_pkg.sv
rtl/core/cqt_datapath.sv
rtl/core/cqt_ctrl.sv
rtl/core/compacting_quantile_tracker.sv
rtl/core/cqt_checker.sv
tb/tb.sv
